// File: rtl/core/srh_pkg.sv
// shared types, constants and helpers for the rotate-sum string hash
// no dependencies; imported by every module of the block

package srh_pkg;

  localparam int unsigned MAX_LEN_DEF = 256;
  localparam int unsigned PASSES_DEF  = 50;
  localparam int unsigned HASH_CHARS  = 13;
  localparam int unsigned DIGIT_W     = 5;
  localparam int unsigned ALPHA_CNT   = 26;

  localparam logic [63:0] HASH_SEED = 64'h1234567801234567;
  localparam logic [6:0]  CHAR_A    = 7'h61;
  localparam logic [6:0]  CHAR_0    = 7'h30;

  // one input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
  } srh_in_t;

  // one result word
  typedef struct packed {
    logic [6:0] hash_char;
    logic       last_char;
    logic       overflow;
  } srh_out_t;

  // head of the front queue as seen by the hash engine
  typedef struct packed {
    logic    valid;
    srh_in_t word;
  } srh_item_t;

  // finished hash handed to the encoder
  typedef struct packed {
    logic        valid;
    logic        overflow;
    logic [63:0] sum;
  } srh_job_t;

  typedef enum logic [1:0] {
    ST_LOAD,
    ST_HASH,
    ST_DONE
  } srh_state_t;

  function automatic logic [63:0] rotr13(input logic [63:0] v);
    return {v[12:0], v[63:13]};
  endfunction

  function automatic logic [6:0] digit_char(input logic [DIGIT_W-1:0] d);
    logic [6:0] c;
    if (d < DIGIT_W'(ALPHA_CNT)) begin
      c = CHAR_A + {2'b00, d};
    end else begin
      c = CHAR_0 + {2'b00, d - DIGIT_W'(ALPHA_CNT)};
    end
    return c;
  endfunction

endpackage

// File: rtl/core/string_rotate_hash_base32.sv
// Rotate-sum string hash with base-32 text output. A string arrives one byte
// word at a time and ends at the word marked last; the hash comes out as 13
// characters, 'a'-'z' and '0'-'5', the last one flagged, all flagged overflow
// if more than MAX_LEN bytes came in (the excess is dropped). The loader pops
// and stores a byte word in the same cycle. After the last word, the engine
// reads its stored bytes PASSES times over (an empty string skips this),
// through the single buffer read port giving one byte per cycle; characters then
// leave at one per cycle while out_pop is held. A two-word input queue keeps
// accepting until full while the engine hashes, and the hash engine starts
// the next string while the previous characters are still being drained.
// depends on srh_pkg, srh_front, srh_back, srh_enc

module string_rotate_hash_base32 #(
  parameter int unsigned MAX_LEN = srh_pkg::MAX_LEN_DEF,
  parameter int unsigned PASSES  = srh_pkg::PASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  srh_pkg::srh_in_t  in_word,
  output logic              out_empty,
  input  logic              out_pop,
  output srh_pkg::srh_out_t out_word
);
  import srh_pkg::*;

  srh_item_t head;
  logic      head_pop;
  srh_job_t  job;
  logic      enc_ready;

  srh_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_full  (in_full),
    .in_word  (in_word),
    .head     (head),
    .head_pop (head_pop)
  );

  srh_back #(
    .MAX_LEN (MAX_LEN),
    .PASSES  (PASSES)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .head_pop  (head_pop),
    .enc_ready (enc_ready),
    .job       (job)
  );

  srh_enc u_enc (
    .clk       (clk),
    .rst_n     (rst_n),
    .job       (job),
    .enc_ready (enc_ready),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  // the final character of a hash leaves the result side empty
  a_last_char_drains: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_pop && out_word.last_char) |=> out_empty)
    else $error("result side not empty after final character");

  // a handed-off hash is registered and then presented from its first character
  a_job_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (job.valid && enc_ready) |=> (!out_empty && !out_word.last_char))
    else $error("handed-off hash not presented from its first character");

  // the input queue fills only through an accepted push
  a_full_by_push: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_full) |-> $past(in_push))
    else $error("input queue filled without a push");

endmodule

// File: rtl/core/srh_front.sv
// input side: accepts words, drops empty non-final words, two-entry queue
// depends on srh_pkg

module srh_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_push,
  output logic               in_full,
  input  srh_pkg::srh_in_t   in_word,
  output srh_pkg::srh_item_t head,
  input  logic               head_pop
);
  import srh_pkg::*;

  srh_in_t    q_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push_ok;
  logic       keep;
  logic       do_pop;

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  // a word with no byte and no end mark changes nothing downstream
  assign keep    = push_ok && (in_word.byte_valid || in_word.last);
  assign do_pop  = head_pop && (cnt_r != 2'd0);

  assign head.valid = (cnt_r != 2'd0);
  assign head.word  = q_r[rp_r];

  always_comb begin
    wp_nxt  = keep ? ~wp_r : wp_r;
    rp_nxt  = do_pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + {1'b0, keep} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (keep) begin
      q_r[wp_r] <= in_word;
    end
  end

endmodule

// File: rtl/core/srh_back.sv
// hash engine: byte buffer, load sequencer and the multi-pass rotate-sum loop
// depends on srh_pkg

module srh_back #(
  parameter int unsigned MAX_LEN = srh_pkg::MAX_LEN_DEF,
  parameter int unsigned PASSES  = srh_pkg::PASSES_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  srh_pkg::srh_item_t head,
  output logic               head_pop,
  input  logic               enc_ready,
  output srh_pkg::srh_job_t  job
);
  import srh_pkg::*;

  localparam int unsigned AW = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned CW = $clog2(MAX_LEN + 1);
  localparam int unsigned PW = (PASSES > 1) ? $clog2(PASSES) : 1;

  logic [7:0]    store_mem [MAX_LEN];

  srh_state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic          ovf_r, ovf_nxt;
  logic [63:0]   sum_r, sum_nxt;
  logic [AW-1:0] pos_r, pos_nxt;
  logic [PW-1:0] pass_r, pass_nxt;
  logic          rd_valid_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    rd_pos_r;
  logic          mem_we;
  logic          mem_rd_en;
  logic [AW+7:0] pos_wide;
  logic [7:0]    pos8;
  logic          last_pos;

  assign pos_wide = {8'd0, pos_r};
  assign pos8     = pos_wide[7:0];
  assign last_pos = (CW'(pos_r) == count_r - CW'(1));

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    ovf_nxt     = ovf_r;
    sum_nxt     = sum_r;
    pos_nxt     = pos_r;
    pass_nxt    = pass_r;
    mem_we      = 1'b0;
    mem_rd_en   = 1'b0;
    head_pop    = 1'b0;
    job.valid    = 1'b0;
    job.overflow = ovf_r;
    job.sum      = sum_r;

    unique case (state_r)
      ST_LOAD: begin
        if (head.valid) begin
          head_pop = 1'b1;
          if (head.word.byte_valid) begin
            if (count_r < CW'(MAX_LEN)) begin
              mem_we    = 1'b1;
              count_nxt = count_r + CW'(1);
            end else begin
              ovf_nxt = 1'b1;
            end
          end
          if (head.word.last) begin
            sum_nxt   = HASH_SEED;
            pos_nxt   = '0;
            pass_nxt  = '0;
            state_nxt = (count_nxt == '0) ? ST_DONE : ST_HASH;
          end
        end
      end
      ST_HASH: begin
        mem_rd_en = 1'b1;
        if (last_pos) begin
          pos_nxt = '0;
          if (pass_r == PW'(PASSES - 1)) begin
            state_nxt = ST_DONE;
          end else begin
            pass_nxt = pass_r + PW'(1);
          end
        end else begin
          pos_nxt = pos_r + AW'(1);
        end
      end
      ST_DONE: begin
        // wait for the final add to land and for the encoder to be free
        if (!rd_valid_r && enc_ready) begin
          job.valid = 1'b1;
          count_nxt = '0;
          ovf_nxt   = 1'b0;
          state_nxt = ST_LOAD;
        end
      end
      default: begin
        state_nxt = ST_LOAD;
      end
    endcase

    // second stage of the read: add the term and rotate
    if (rd_valid_r) begin
      sum_nxt = rotr13(sum_r + {56'd0, rd_data_r ^ rd_pos_r});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_LOAD;
      count_r    <= '0;
      ovf_r      <= 1'b0;
      sum_r      <= HASH_SEED;
      pos_r      <= '0;
      pass_r     <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      count_r    <= count_nxt;
      ovf_r      <= ovf_nxt;
      sum_r      <= sum_nxt;
      pos_r      <= pos_nxt;
      pass_r     <= pass_nxt;
      rd_valid_r <= mem_rd_en;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      store_mem[count_r[AW-1:0]] <= head.word.data_byte;
    end
    if (mem_rd_en) begin
      rd_data_r <= store_mem[pos_r];
      rd_pos_r  <= pos8;
    end
  end

endmodule

// File: rtl/core/srh_enc.sv
// result side: holds a finished hash and shifts out one base-32 character a word
// depends on srh_pkg

module srh_enc (
  input  logic              clk,
  input  logic              rst_n,
  input  srh_pkg::srh_job_t job,
  output logic              enc_ready,
  output logic              out_empty,
  input  logic              out_pop,
  output srh_pkg::srh_out_t out_word
);
  import srh_pkg::*;

  localparam int unsigned IW = $clog2(HASH_CHARS);

  logic [63:0]   shift_r, shift_nxt;
  logic          ovf_r, ovf_nxt;
  logic [IW-1:0] idx_r, idx_nxt;
  logic          busy_r, busy_nxt;
  logic          at_last;

  assign enc_ready = !busy_r;
  assign out_empty = !busy_r;
  assign at_last   = (idx_r == IW'(HASH_CHARS - 1));

  assign out_word.hash_char = digit_char(shift_r[DIGIT_W-1:0]);
  assign out_word.last_char = at_last;
  assign out_word.overflow  = ovf_r;

  always_comb begin
    shift_nxt = shift_r;
    ovf_nxt   = ovf_r;
    idx_nxt   = idx_r;
    busy_nxt  = busy_r;
    if (!busy_r) begin
      if (job.valid) begin
        shift_nxt = job.sum;
        ovf_nxt   = job.overflow;
        idx_nxt   = '0;
        busy_nxt  = 1'b1;
      end
    end else if (out_pop) begin
      shift_nxt = shift_r >> DIGIT_W;
      idx_nxt   = idx_r + IW'(1);
      if (at_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      idx_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      idx_r  <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    shift_r <= shift_nxt;
    ovf_r   <= ovf_nxt;
  end

endmodule
